// ===== hw/rtl/cbra_pkg.sv =====
// Shared constants and controller/datapath interface types for the block run allocator.
`timescale 1ns / 1ps

package cbra_pkg;

    localparam int NUM_BLOCKS   = 128;
    localparam int BLOCK_BYTES  = 256;
    localparam int HEADER_BYTES = 16;

    localparam int IDX_W     = $clog2(NUM_BLOCKS);
    localparam int POS_W     = IDX_W + 1;
    localparam int BLOCK_LG2 = $clog2(BLOCK_BYTES);
    localparam int REQ_W     = 16;
    localparam int NEED_W    = REQ_W - BLOCK_LG2 + 1;
    localparam int SUM_W     = NEED_W + 1;
    localparam int HDR_W     = 8;
    localparam int OFF_W     = 15;

    localparam logic [HDR_W-1:0] HDR_FREE_ONE = 8'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic load_in;
        logic alloc_start;
        logic scan_step;
        logic alloc_commit;
        logic free_start;
        logic free_head;
        logic clr_step;
        logic set_fail;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic alloc_fits;
        logic scan_more;
        logic scan_hit;
        logic free_valid;
        logic head_used;
        logic clr_more;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/cbra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cbra_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cbra_datapath.sv =====
// Datapath: header RAM, valid bits, scan and free registers, result output register.
`timescale 1ns / 1ps

module cbra_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cbra_pkg::t_cmd  i_cmd,
    output cbra_pkg::t_sts  o_sts,
    input  logic [31:0]     i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [15:0]     o_out_data
);

    localparam int IDX_W = cbra_pkg::IDX_W;
    localparam int POS_W = cbra_pkg::POS_W;
    localparam int HDR_W = cbra_pkg::HDR_W;
    localparam int OFF_W = cbra_pkg::OFF_W;
    localparam int NEED_W = cbra_pkg::NEED_W;
    localparam int SUM_W = cbra_pkg::SUM_W;
    localparam int LG2 = cbra_pkg::BLOCK_LG2;
    localparam int REQ_W = cbra_pkg::REQ_W;

    logic [NEED_W-1:0]          r_need;
    logic [REQ_W-1:0]           r_off_in;
    logic [IDX_W-1:0]           r_ss;
    logic [POS_W-1:0]           r_pos;
    logic [IDX_W-1:0]           r_head;
    logic [IDX_W-1:0]           r_count;
    logic [IDX_W-1:0]           r_len;
    logic [IDX_W-1:0]           r_k;
    logic [cbra_pkg::NUM_BLOCKS-1:0] r_vld;
    logic                       r_ok;
    logic [OFF_W-1:0]           r_off;
    logic                       r_m_valid;
    logic                       r_m_ok;
    logic [OFF_W-1:0]           r_m_off;

    logic [HDR_W-1:0] ram_rdata;
    logic [HDR_W-1:0] hdr_eff;
    logic [IDX_W-1:0] hdr_len;
    logic [IDX_W-1:0] step_len;
    logic [POS_W-1:0] scan_pos;
    logic [IDX_W-1:0] scan_cnt;
    logic [IDX_W-1:0] scan_head;
    logic [REQ_W-1:0] rel;
    logic [IDX_W-1:0] free_idx;
    logic [POS_W-1:0] clr_pos;
    logic [OFF_W-1:0] grant_off;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [HDR_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;

    // Entries never written read as free, length one.
    assign hdr_eff  = r_vld[r_pos[IDX_W-1:0]] ? ram_rdata : cbra_pkg::HDR_FREE_ONE;
    assign hdr_len  = hdr_eff[HDR_W-1:1];
    assign step_len = (hdr_len == '0) ? IDX_W'(1) : hdr_len;

    // One scan step: skip a used head's run, or count one more free block.
    assign scan_pos  = hdr_eff[0] ? r_pos + POS_W'(step_len) : r_pos + POS_W'(1);
    assign scan_cnt  = hdr_eff[0] ? '0 : r_count + IDX_W'(1);
    assign scan_head = hdr_eff[0] ? scan_pos[IDX_W-1:0] : r_head;
    assign grant_off = OFF_W'((32'(scan_head) << LG2) + 32'(cbra_pkg::HEADER_BYTES));

    assign rel      = r_off_in - REQ_W'(cbra_pkg::HEADER_BYTES);
    assign free_idx = rel[LG2 +: IDX_W];
    assign clr_pos  = r_pos + POS_W'(r_k);

    always_comb begin
        o_sts.alloc_fits = (SUM_W'(r_ss) + SUM_W'(r_need)) < SUM_W'(cbra_pkg::NUM_BLOCKS);
        o_sts.scan_more  = (NEED_W'(scan_cnt) < r_need)
                           && (scan_pos < POS_W'(cbra_pkg::NUM_BLOCKS));
        o_sts.scan_hit   = scan_pos < POS_W'(cbra_pkg::NUM_BLOCKS);
        o_sts.free_valid = (r_off_in >= REQ_W'(cbra_pkg::HEADER_BYTES))
                           && ({1'b0, r_off_in}
                               < (REQ_W+1)'(cbra_pkg::NUM_BLOCKS * cbra_pkg::BLOCK_BYTES))
                           && (rel[LG2-1:0] == '0);
        o_sts.head_used  = hdr_eff[0];
        o_sts.clr_more   = (r_k < r_len) && (clr_pos < POS_W'(cbra_pkg::NUM_BLOCKS));
        o_sts.out_free   = !r_m_valid || i_out_ready;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos[IDX_W-1:0];
        ram_wdata = {hdr_eff[HDR_W-1:1], 1'b0};
        if (i_cmd.alloc_commit) begin
            ram_we    = 1'b1;
            ram_waddr = scan_head;
            ram_wdata = {r_need[IDX_W-1:0], 1'b1};
        end else if (i_cmd.free_head) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        ram_raddr = r_pos[IDX_W-1:0];
        if (i_cmd.alloc_start) begin
            ram_raddr = r_ss;
        end else if (i_cmd.scan_step) begin
            ram_raddr = scan_pos[IDX_W-1:0];
        end else if (i_cmd.free_start) begin
            ram_raddr = free_idx;
        end
    end

    cbra_ram #(
        .WIDTH (HDR_W),
        .DEPTH (cbra_pkg::NUM_BLOCKS)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_ss      <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_vld[clr_pos[IDX_W-1:0]] <= 1'b0;
            end
            if (i_cmd.alloc_commit) begin
                r_ss <= scan_pos[IDX_W-1:0];
            end else if (i_cmd.free_start && (free_idx < r_ss)) begin
                r_ss <= free_idx;
            end
            if (i_cmd.push) begin
                r_m_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_need   <= NEED_W'(i_in_data[REQ_W-1:0] >> LG2) + NEED_W'(1);
            r_off_in <= i_in_data[2*REQ_W-1:REQ_W];
        end
        if (i_cmd.alloc_start) begin
            r_pos   <= POS_W'(r_ss);
            r_head  <= r_ss;
            r_count <= '0;
        end else if (i_cmd.scan_step) begin
            r_pos   <= scan_pos;
            r_head  <= scan_head;
            r_count <= scan_cnt;
        end else if (i_cmd.free_start) begin
            r_pos <= POS_W'(free_idx);
        end
        if (i_cmd.free_head) begin
            r_len <= hdr_len;
            r_k   <= IDX_W'(1);
        end else if (i_cmd.clr_step) begin
            r_k <= r_k + IDX_W'(1);
        end
        if (i_cmd.set_fail) begin
            r_ok  <= 1'b0;
            r_off <= '0;
        end else if (i_cmd.alloc_commit) begin
            r_ok  <= 1'b1;
            r_off <= grant_off;
        end else if (i_cmd.free_head) begin
            r_ok  <= 1'b1;
            r_off <= '0;
        end
        if (i_cmd.push) begin
            r_m_ok  <= r_ok;
            r_m_off <= r_off;
        end
    end

    assign o_out_valid = r_m_valid;
    assign o_out_data  = {r_m_off, r_m_ok};

endmodule

// ===== hw/rtl/cbra_ctrl.sv =====
// Controller state machine sequencing allocate scans and free run resets.
`timescale 1ns / 1ps

module cbra_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_action,
    output logic           o_in_ready,
    input  cbra_pkg::t_sts i_sts,
    output cbra_pkg::t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACHK = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_FCHK = 3'd3;
    localparam logic [2:0] ST_FRD  = 3'd4;
    localparam logic [2:0] ST_FCLR = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_in_action == cbra_pkg::ACT_FREE) ? ST_FCHK : ST_ACHK;
                end
            end
            ST_ACHK: begin
                if (i_sts.alloc_fits) begin
                    o_cmd.alloc_start = 1'b1;
                    n_state = ST_SCAN;
                end else begin
                    o_cmd.set_fail = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (!i_sts.scan_more) begin
                    if (i_sts.scan_hit) begin
                        o_cmd.alloc_commit = 1'b1;
                    end else begin
                        o_cmd.set_fail = 1'b1;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_FCHK: begin
                if (i_sts.free_valid) begin
                    o_cmd.free_start = 1'b1;
                    n_state = ST_FRD;
                end else begin
                    o_cmd.set_fail = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_FRD: begin
                if (i_sts.head_used) begin
                    o_cmd.free_head = 1'b1;
                    n_state = ST_FCLR;
                end else begin
                    o_cmd.set_fail = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_FCLR: begin
                if (i_sts.clr_more) begin
                    o_cmd.clr_step = 1'b1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/contiguous_block_run_allocator.sv =====
// Top level of the next-fit contiguous block run allocator.
`timescale 1ns / 1ps

// Manages 128 blocks of 256 bytes, each with an 8-bit header (used bit, run length)
// held in a 128-entry RAM; a valid bit per entry makes every header read as free,
// length one right after reset, so no clearing pass is needed. One word in gives one
// word out. An allocate (tuser = 0) that fails the size check goes straight to the
// result; else the scan visits at most 128 headers, one per cycle through the
// registered RAM read, and a used head's run is skipped in one step. A free
// (tuser = 1) is ignored when its offset is not valid, fails when it does not land on
// a used head, and else clears the released run (at least one block long, cut at the
// last block). The output register load waits while that register still holds
// an unaccepted word; once it is loaded, input is taken again while the word waits
// downstream.
module contiguous_block_run_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] request_bytes, [31:16] free_offset
    input  logic        s_axis_tuser,   // [0] action (0 allocate, 1 free)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] ok, [15:1] payload_offset
);

    cbra_pkg::t_cmd cmd;
    cbra_pkg::t_sts sts;

    // Sequencer: one item at a time
    cbra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_action (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Header store, search pointer and result register
    cbra_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    // Once a word is taken the block is busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted word");

    // A failed or ignored request never carries an offset.
    a_fail_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[15:1] == '0))
        else $error("offset returned with a failed result");

    // A granted offset always sits just past a block header.
    a_grant_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0] && (m_axis_tdata[15:1] != '0))
        |-> (m_axis_tdata[cbra_pkg::BLOCK_LG2:1]
             == cbra_pkg::BLOCK_LG2'(cbra_pkg::HEADER_BYTES)))
        else $error("granted offset not on a payload boundary");

endmodule
